// ----- src/mtt_pkg.sv -----
// Package with the constants, codes and sine table of the millidegree trig unit.
`default_nettype none

package mtt_pkg;

  // Operation codes.
  localparam logic [1:0] OpSine    = 2'd0;
  localparam logic [1:0] OpCosine  = 2'd1;
  localparam logic [1:0] OpTangent = 2'd2;

  // Angle constants in millidegrees.
  localparam int FullTurn     = 360000;
  localparam int Quarter      = 90000;
  localparam int HalfTurn     = 180000;
  localparam int ThreeQuarter = 270000;

  // The input angle is biased by 2^31 to make it unsigned; this is 2^31 mod 360000.
  localparam int BiasRem = 83648;

  // 360000 = 64 * 5625, so the quotient comes from (u >> 6) times a reciprocal of 5625.
  localparam int RecipShift = 38;
  localparam logic [25:0] RecipTurn = 26'((64'd1 << RecipShift) / 64'd5625);

  // Reciprocal of 1000 for taking the whole-degree part of a folded angle.
  localparam int DegShift = 27;
  localparam logic [17:0] RecipDeg = 18'(((64'd1 << DegShift) + 64'd999) / 64'd1000);

  localparam logic [31:0] TanSat = 32'h7FFF_FFFF;

  // Entry d holds 1000 * sin(d degrees), truncated.
  localparam logic [9:0] SineRom [91] = '{
    10'd0,   10'd17,  10'd34,  10'd52,  10'd69,  10'd87,  10'd104, 10'd121, 10'd139, 10'd156,
    10'd173, 10'd190, 10'd207, 10'd224, 10'd241, 10'd258, 10'd275, 10'd292, 10'd309, 10'd325,
    10'd342, 10'd358, 10'd374, 10'd390, 10'd406, 10'd422, 10'd438, 10'd453, 10'd469, 10'd484,
    10'd500, 10'd515, 10'd529, 10'd544, 10'd559, 10'd573, 10'd587, 10'd601, 10'd615, 10'd629,
    10'd642, 10'd656, 10'd669, 10'd681, 10'd694, 10'd707, 10'd719, 10'd731, 10'd743, 10'd754,
    10'd766, 10'd777, 10'd788, 10'd798, 10'd809, 10'd819, 10'd829, 10'd838, 10'd848, 10'd857,
    10'd866, 10'd874, 10'd882, 10'd891, 10'd898, 10'd906, 10'd913, 10'd920, 10'd927, 10'd933,
    10'd939, 10'd945, 10'd951, 10'd956, 10'd961, 10'd965, 10'd970, 10'd974, 10'd978, 10'd981,
    10'd984, 10'd987, 10'd990, 10'd992, 10'd994, 10'd996, 10'd997, 10'd998, 10'd999, 10'd999,
    10'd1000
  };

  // Side information that travels next to the divider.
  typedef struct packed {
    logic [1:0]        op;
    logic signed [10:0] sval;
    logic signed [10:0] cval;
    logic              czero;
    logic              negq;
  } side_t;

endpackage

`default_nettype wire

// ----- src/mtt_if.sv -----
// Handshake interfaces for the angle input channel and the result channel.
`default_nettype none

interface mtt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [31:0] angle;

  modport source (output valid, output opcode, output angle, input ready);
  modport sink (input valid, input opcode, input angle, output ready);
endinterface

interface mtt_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- src/mtt_div.sv -----
// Three-stage restoring divider of small magnitudes, two quotient bits per stage.
`default_nettype none

module mtt_div (
  input  wire logic       clk_i,
  input  wire logic [2:0] en_i,
  input  wire logic [9:0] num_i,
  input  wire logic [9:0] den_i,
  output logic [5:0]      quot_o
);
  import mtt_pkg::*;

  logic [9:0] rem_q  [2];
  logic [9:0] rem_d  [3];
  logic [9:0] den_q  [2];
  logic [5:0] quot_q [3];
  logic [5:0] quot_d [3];

  // Two restoring steps for quotient bits hi and hi-1; returns {quotient, remainder}.
  function automatic logic [15:0] step2(logic [9:0] rem, logic [9:0] den,
                                        logic [5:0] quot, int unsigned hi);
    logic [15:0] r;
    logic [15:0] d;
    logic [5:0]  q;
    r = {6'b0, rem};
    q = quot;
    for (int unsigned k = 0; k < 2; k++) begin
      d = {6'b0, den} << (hi - k);
      if (r >= d) begin
        r = r - d;
        q[hi - k] = 1'b1;
      end
    end
    return {q, r[9:0]};
  endfunction

  always_comb begin
    {quot_d[0], rem_d[0]} = step2(num_i, den_i, 6'b0, 5);
    {quot_d[1], rem_d[1]} = step2(rem_q[0], den_q[0], quot_q[0], 3);
    {quot_d[2], rem_d[2]} = step2(rem_q[1], den_q[1], quot_q[1], 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= rem_d[0];
      quot_q[0] <= quot_d[0];
      den_q[0]  <= den_i;
    end
    if (en_i[1]) begin
      rem_q[1]  <= rem_d[1];
      quot_q[1] <= quot_d[1];
      den_q[1]  <= den_q[0];
    end
    if (en_i[2]) begin
      quot_q[2] <= quot_d[2];
    end
  end

  assign quot_o = quot_q[2];

endmodule

`default_nettype wire

// ----- src/millidegree_table_trig_unit.sv -----
// Millidegree sine, cosine and tangent unit: ten-stage pipeline with a quarter-wave table.
//
// Usage: items arrive on in_i (opcode, signed angle in millidegrees) and results
// leave on out_o (value), both valid/ready channels; an item moves when valid
// and ready are high at a rising clock edge. Opcode 0 gives 1000*sin, 1 gives
// 1000*cos, 2 gives the truncated ratio sin/cos (0x7FFFFFFF when the cosine
// entry is zero) and 3 gives zero.
// Depth: an accepted item passes in order through the ten register stages:
// reciprocal multiply, remainder, wrap, quadrant fold, degree multiply, table
// read, three divider stages of two quotient bits each, and the output
// register, from which it leaves on out_o. While out_o.ready is high, every
// stage passes an item on each cycle, so one item is accepted every cycle.
// Every stage holds its own valid bit and advances when it is empty or the next
// stage moves, so a stall at out_o fills the bubbles first and then holds
// in_i.ready low; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline; no other state exists.
`default_nettype none

module millidegree_table_trig_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtt_in_if.sink    in_i,
  mtt_out_if.source out_o
);
  import mtt_pkg::*;

  localparam int NumStages = 10;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  // Stage 0: biased angle and reciprocal product.
  logic [31:0] u0_q;
  logic [51:0] prod0_q;
  logic [51:0] prod0_d;
  logic [1:0]  op0_q;
  // Stage 1: remainder, possibly one turn too large.
  logic [19:0] r1_q;
  logic [19:0] r1_d;
  logic [32:0] diff1;
  logic [1:0]  op1_q;
  // Stage 2: angle reduced to one turn.
  logic [18:0] a2_q;
  logic [18:0] a2_d;
  logic [19:0] r2;
  logic [1:0]  op2_q;
  // Stage 3: folded offsets and quadrant signs.
  logic [16:0] sx3_q, cx3_q, sx3_d, cx3_d;
  logic        sneg3_q, cneg3_q, sneg3_d, cneg3_d;
  logic [1:0]  op3_q;
  // Stage 4: table indexes.
  logic [34:0] sprod4, cprod4;
  logic [6:0]  sidx4_q, cidx4_q;
  logic        sneg4_q, cneg4_q;
  logic [1:0]  op4_q;
  // Stage 5: table values.
  logic [9:0]  smag5_q, cmag5_q;
  logic        sneg5_q, cneg5_q;
  logic [1:0]  op5_q;
  // Stages 6 to 8: divider and side information.
  side_t       side_q [3];
  side_t       side_d;
  logic [5:0]  quot;
  // Stage 9: result.
  logic [31:0] value_q;
  logic [31:0] value_d;

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0: floor(u / 360000) equals floor((u >> 6) / 5625).
  assign prod0_d = 52'({~in_i.angle[31], in_i.angle[30:6]}) * 52'(RecipTurn);

  // Stage 1: the estimated quotient is exact or one low, so the remainder is below two turns.
  assign diff1 = {1'b0, u0_q} - 33'(prod0_q[51:RecipShift]) * 33'(FullTurn);
  assign r1_d  = diff1[19:0];

  // Stage 2: finish the remainder, then remove the bias of the unsigned form.
  always_comb begin
    r2 = (r1_q >= 20'(FullTurn)) ? r1_q - 20'(FullTurn) : r1_q;
    if (r2 < 20'(BiasRem)) begin
      a2_d = 19'(r2 + 20'(FullTurn - BiasRem));
    end else begin
      a2_d = 19'(r2 - 20'(BiasRem));
    end
  end

  // Stage 3: fold into the first quadrant.
  always_comb begin
    if (a2_q <= 19'(Quarter)) begin
      sx3_d = a2_q[16:0];
      cx3_d = 17'(19'(Quarter) - a2_q);
      sneg3_d = 1'b0;
      cneg3_d = 1'b0;
    end else if (a2_q <= 19'(HalfTurn)) begin
      sx3_d = 17'(19'(HalfTurn) - a2_q);
      cx3_d = 17'(a2_q - 19'(Quarter));
      sneg3_d = 1'b0;
      cneg3_d = 1'b1;
    end else if (a2_q <= 19'(ThreeQuarter)) begin
      sx3_d = 17'(a2_q - 19'(HalfTurn));
      cx3_d = 17'(19'(ThreeQuarter) - a2_q);
      sneg3_d = 1'b1;
      cneg3_d = 1'b1;
    end else begin
      sx3_d = 17'(19'(FullTurn) - a2_q);
      cx3_d = 17'(a2_q - 19'(ThreeQuarter));
      sneg3_d = 1'b1;
      cneg3_d = 1'b0;
    end
  end

  // Stage 4: whole degrees of each offset by a reciprocal of 1000.
  assign sprod4 = 35'(sx3_q) * 35'(RecipDeg);
  assign cprod4 = 35'(cx3_q) * 35'(RecipDeg);

  // Stage 6 input: signed table values and the tangent sign.
  always_comb begin
    side_d.op    = op5_q;
    side_d.sval  = sneg5_q ? -$signed({1'b0, smag5_q}) : $signed({1'b0, smag5_q});
    side_d.cval  = cneg5_q ? -$signed({1'b0, cmag5_q}) : $signed({1'b0, cmag5_q});
    side_d.czero = (cmag5_q == 10'd0);
    side_d.negq  = sneg5_q ^ cneg5_q;
  end

  mtt_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[8:6]),
    .num_i  (smag5_q),
    .den_i  (cmag5_q),
    .quot_o (quot)
  );

  // Stage 9: select the result.
  always_comb begin
    case (side_q[2].op)
      OpSine:   value_d = {{21{side_q[2].sval[10]}}, side_q[2].sval};
      OpCosine: value_d = {{21{side_q[2].cval[10]}}, side_q[2].cval};
      OpTangent: begin
        if (side_q[2].czero) begin
          value_d = TanSat;
        end else if (side_q[2].negq) begin
          value_d = -{26'b0, quot};
        end else begin
          value_d = {26'b0, quot};
        end
      end
      default:  value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u0_q    <= {~in_i.angle[31], in_i.angle[30:0]};
      prod0_q <= prod0_d;
      op0_q   <= in_i.opcode;
    end
    if (en[1]) begin
      r1_q  <= r1_d;
      op1_q <= op0_q;
    end
    if (en[2]) begin
      a2_q  <= a2_d;
      op2_q <= op1_q;
    end
    if (en[3]) begin
      sx3_q   <= sx3_d;
      cx3_q   <= cx3_d;
      sneg3_q <= sneg3_d;
      cneg3_q <= cneg3_d;
      op3_q   <= op2_q;
    end
    if (en[4]) begin
      sidx4_q <= sprod4[DegShift+6:DegShift];
      cidx4_q <= cprod4[DegShift+6:DegShift];
      sneg4_q <= sneg3_q;
      cneg4_q <= cneg3_q;
      op4_q   <= op3_q;
    end
    if (en[5]) begin
      smag5_q <= SineRom[sidx4_q];
      cmag5_q <= SineRom[cidx4_q];
      sneg5_q <= sneg4_q;
      cneg5_q <= cneg4_q;
      op5_q   <= op4_q;
    end
    if (en[6]) side_q[0] <= side_d;
    if (en[7]) side_q[1] <= side_q[0];
    if (en[8]) side_q[2] <= side_q[1];
    if (en[9]) value_q <= value_d;
  end

  assign out_o.valid = vld_q[NumStages-1];
  assign out_o.value = value_q;

endmodule

`default_nettype wire
